[rtl/spifram_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spifram_pkg
// Shared types and constants of the SPI FRAM command sequencer: function and
// status codes, opcodes, phase encoding and the result record.
// ----------------------------------------------------------------------------
package spifram_pkg;

    // address bytes sent after the opcode, high byte first
    localparam int AddrBytes = 3;
    // longest sequence: write-enable, opcode, address bytes
    localparam int SeqMax    = AddrBytes + 2;
    localparam int CntW      = $clog2(SeqMax + 1);
    localparam int ByteIdxW  = $clog2(AddrBytes);

    localparam int AddrW     = 24;
    localparam int CountW    = 16;
    localparam int TopW      = 25;
    localparam int ApbAddrW  = 3;
    localparam int ApbDataW  = 32;

    localparam logic [TopW-1:0] MemTopReset = 25'd262144;

    // register word index (paddr above the byte lanes)
    localparam logic [ApbAddrW-3:0] RegMemoryTop = '0;

    localparam logic [7:0] OpWren  = 8'h06;
    localparam logic [7:0] OpWrite = 8'h02;
    localparam logic [7:0] OpRead  = 8'h03;
    localparam logic [7:0] OpSleep = 8'hB9;

    typedef enum logic [2:0] {
        FUNC_READ  = 3'd0,
        FUNC_WRITE = 3'd1,
        FUNC_FILL  = 3'd2,
        FUNC_SLEEP = 3'd3,
        FUNC_WAKE  = 3'd4,
        FUNC_DATA  = 3'd5,
        FUNC_RECV  = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_RANGE      = 3'd1,
        ST_BUSY       = 3'd2,
        ST_ASLEEP     = 3'd3,
        ST_UNEXPECTED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_READ  = 4'b0010,
        PH_WRITE = 4'b0100,
        PH_FILL  = 4'b1000
    } phase_t;

    typedef struct packed {
        status_t    status;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_assert;
        logic       release_after;
        logic       wake_wait;
        logic       rx_valid;
        logic [7:0] rx_data;
    } result_t;

endpackage
`default_nettype wire

[rtl/spi_fram_command_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spi_fram_command_sequencer
// Turns memory requests into chip-select framed SPI FRAM byte sequences.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests (read/write/fill start, sleep, wakeup, payload or
//   pace byte, received byte); m_* carries the byte-level results, one per
//   transaction, with m_last on the final result of each request.
//   memory_top is written over the APB port at byte address 0; the user must
//   write it only while idle, which the block does not enforce.
//   The first result of a request is registered and shows in the cycle after
//   it is taken. Data, sleep, wakeup and refused requests give one result and
//   pass at one per cycle while m_ready is high. A read start gives opcode and
//   address bytes (4 results), a write or fill start also write-enable (5);
//   the pending sequence buffer emits one result per cycle while m_ready is
//   high and takes the next request in the cycle its last result is taken.
// Reset:
//   aresetn low clears the pending sequence, sets phase idle, the byte count
//   and fill byte to zero, memory_top to 262144 and the asleep flag.
// Stall:
//   while m_ready is low the current result holds and s_ready stays low once
//   a result is pending.
// ----------------------------------------------------------------------------
module spi_fram_command_sequencer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // request channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [2:0]                     s_func,
    input  wire logic [spifram_pkg::AddrW-1:0]  s_start_addr,
    input  wire logic [spifram_pkg::CountW-1:0] s_byte_count,
    input  wire logic [7:0]                     s_byte_value,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [2:0]                          m_status,
    output logic                                m_tx_valid,
    output logic [7:0]                          m_tx_byte,
    output logic                                m_select_assert,
    output logic                                m_release_after,
    output logic                                m_wake_wait,
    output logic                                m_rx_valid,
    output logic [7:0]                          m_rx_data,
    output logic                                m_last,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [spifram_pkg::ApbAddrW-1:0] paddr,
    input  wire logic [spifram_pkg::ApbDataW-1:0] pwdata,
    output logic      [spifram_pkg::ApbDataW-1:0] prdata,
    output logic                                  pready
);
    import spifram_pkg::*;

    // configuration and sequencer state
    logic [TopW-1:0]   mem_top_reg;
    phase_t            phase_reg, phase_next;
    logic [CountW-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]        fill_byte_reg, fill_byte_next;
    logic              asleep_reg, asleep_next;

    // pending result buffer
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [CntW-1:0]   pos_reg, pos_next;
    logic              is_seq_reg, is_seq_new;
    result_t           single_reg, single_new;
    logic              wren_reg, wren_new;
    logic [7:0]        op_reg, op_new;
    logic              ww_reg, ww_new;
    logic              zero_reg, zero_new;
    logic [AddrW-1:0]  addr_reg;
    logic [CntW-1:0]   cnt_new;

    logic              s_fire, m_fire, cfg_write, in_range;
    logic [CountW-1:0] bl_dec;
    result_t           res;
    logic [CntW-1:0]   base, addr_k;
    logic [ByteIdxW-1:0] byte_idx;
    logic [31:0]       addr_shifted;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[ApbAddrW-1:2] == RegMemoryTop);
    assign prdata    = (paddr[ApbAddrW-1:2] == RegMemoryTop)
                       ? {{(ApbDataW-TopW){1'b0}}, mem_top_reg} : '0;

    assign m_valid = (cnt_reg != '0);
    assign s_ready = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign in_range = ({1'b0, s_start_addr} < mem_top_reg);
    assign bl_dec   = bytes_left_reg - CountW'(1);

    // decode one request against the current state
    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        fill_byte_next  = fill_byte_reg;
        asleep_next     = asleep_reg;
        is_seq_new      = 1'b0;
        single_new      = '0;
        single_new.status = ST_OK;
        wren_new        = 1'b0;
        op_new          = OpRead;
        ww_new          = 1'b0;
        zero_new        = (s_byte_count == '0);
        cnt_new         = CntW'(1);
        case (s_func)
            FUNC_READ, FUNC_WRITE, FUNC_FILL: begin
                if (!in_range) begin
                    single_new.status = ST_RANGE;
                end else if (phase_reg != PH_IDLE) begin
                    single_new.status = ST_BUSY;
                end else begin
                    is_seq_new  = 1'b1;
                    ww_new      = asleep_reg;
                    asleep_next = 1'b0;
                    wren_new    = (s_func != FUNC_READ);
                    op_new      = (s_func == FUNC_READ) ? OpRead : OpWrite;
                    cnt_new     = (s_func == FUNC_READ) ? CntW'(AddrBytes + 1)
                                                        : CntW'(AddrBytes + 2);
                    if (s_func == FUNC_FILL) begin
                        fill_byte_next = s_byte_value;
                    end
                    if (s_byte_count != '0) begin
                        bytes_left_next = s_byte_count;
                        phase_next = (s_func == FUNC_READ)  ? PH_READ :
                                     (s_func == FUNC_WRITE) ? PH_WRITE : PH_FILL;
                    end
                end
            end
            FUNC_SLEEP: begin
                if (asleep_reg) begin
                    single_new.status = ST_ASLEEP;
                end else if (phase_reg != PH_IDLE) begin
                    single_new.status = ST_BUSY;
                end else begin
                    single_new.tx_valid      = 1'b1;
                    single_new.tx_byte       = OpSleep;
                    single_new.select_assert = 1'b1;
                    single_new.release_after = 1'b1;
                    asleep_next = 1'b1;
                end
            end
            FUNC_WAKE: begin
                // awake already: plain ok, no pulse
                if (asleep_reg) begin
                    if (phase_reg != PH_IDLE) begin
                        single_new.status = ST_BUSY;
                    end else begin
                        single_new.select_assert = 1'b1;
                        single_new.release_after = 1'b1;
                        single_new.wake_wait     = 1'b1;
                        asleep_next = 1'b0;
                    end
                end
            end
            FUNC_DATA: begin
                if (phase_reg != PH_WRITE && phase_reg != PH_FILL) begin
                    single_new.status = ST_UNEXPECTED;
                end else begin
                    bytes_left_next          = bl_dec;
                    single_new.tx_valid      = 1'b1;
                    single_new.tx_byte       = (phase_reg == PH_FILL) ? fill_byte_reg
                                                                      : s_byte_value;
                    single_new.release_after = (bl_dec == '0);
                    if (bl_dec == '0) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            FUNC_RECV: begin
                if (phase_reg != PH_READ) begin
                    single_new.status = ST_UNEXPECTED;
                end else begin
                    bytes_left_next          = bl_dec;
                    single_new.rx_valid      = 1'b1;
                    single_new.rx_data       = s_byte_value;
                    single_new.release_after = (bl_dec == '0);
                    if (bl_dec == '0) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                single_new.status = ST_UNEXPECTED;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (s_fire) begin
            cnt_next = cnt_new;
            pos_next = '0;
        end else if (m_fire) begin
            cnt_next = cnt_reg - CntW'(1);
            pos_next = pos_reg + CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_top_reg    <= MemTopReset;
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            fill_byte_reg  <= '0;
            asleep_reg     <= 1'b1;
            cnt_reg        <= '0;
            pos_reg        <= '0;
        end else begin
            if (cfg_write) begin
                mem_top_reg <= pwdata[TopW-1:0];
            end
            if (s_fire) begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                fill_byte_reg  <= fill_byte_next;
                asleep_reg     <= asleep_next;
            end
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            is_seq_reg <= is_seq_new;
            single_reg <= single_new;
            wren_reg   <= wren_new;
            op_reg     <= op_new;
            ww_reg     <= ww_new;
            zero_reg   <= zero_new;
            addr_reg   <= s_start_addr;
        end
    end

    // header sequence: [write-enable frame], opcode, address bytes high first
    assign base         = wren_reg ? CntW'(2) : CntW'(1);
    assign addr_k       = pos_reg - base;
    assign byte_idx     = ByteIdxW'(CntW'(AddrBytes - 1) - addr_k);
    assign addr_shifted = {{(32-AddrW){1'b0}}, addr_reg} >> {byte_idx, 3'b000};

    always_comb begin
        res        = '0;
        res.status = ST_OK;
        if (!is_seq_reg) begin
            res = single_reg;
        end else begin
            res.tx_valid = 1'b1;
            if (wren_reg && pos_reg == '0) begin
                res.tx_byte       = OpWren;
                res.select_assert = 1'b1;
                res.release_after = 1'b1;
                res.wake_wait     = ww_reg;
            end else if (pos_reg == base - CntW'(1)) begin
                res.tx_byte       = op_reg;
                res.select_assert = 1'b1;
                res.wake_wait     = ww_reg && !wren_reg;
            end else begin
                res.tx_byte       = addr_shifted[7:0];
                res.release_after = (byte_idx == '0) && zero_reg;
            end
        end
    end

    assign m_status        = res.status;
    assign m_tx_valid      = res.tx_valid;
    assign m_tx_byte       = res.tx_byte;
    assign m_select_assert = res.select_assert;
    assign m_release_after = res.release_after;
    assign m_wake_wait     = res.wake_wait;
    assign m_rx_valid      = res.rx_valid;
    assign m_rx_data       = res.rx_data;
    assign m_last          = (cnt_reg == CntW'(1));

endmodule
`default_nettype wire

[rtl/spifram_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spifram_chk
// Port-level checks of the SPI FRAM command sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module spifram_chk (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_status,
    input wire logic       m_tx_valid,
    input wire logic [7:0] m_tx_byte,
    input wire logic       m_rx_valid,
    input wire logic       m_last
);
    import spifram_pkg::*;

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // a stalled transaction holds its byte
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_last))
        else $error("stalled result changed");

    // refused requests give a single result
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_last)
        else $error("error result not last");

    // input only blocked by pending results
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with nothing pending");

    // a read byte never goes out on the bus
    a_rx_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_valid |-> !m_tx_valid && m_status == ST_OK)
        else $error("read byte with tx or error");

endmodule

bind spi_fram_command_sequencer spifram_chk u_spifram_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_tx_valid (m_tx_valid),
    .m_tx_byte  (m_tx_byte),
    .m_rx_valid (m_rx_valid),
    .m_last     (m_last)
);
`default_nettype wire
